>>> src/closing_fee_negotiator_defines.svh
// assertion macros for the closing fee negotiator
// included by the modules that carry assertions
`ifndef CLOSING_FEE_NEGOTIATOR_DEFINES_SVH
`define CLOSING_FEE_NEGOTIATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CFN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cfn assertion failed");
`define CFN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cfn assertion failed");
`else
`define CFN_ASSERT(lbl, clk, rst_n, prop)
`define CFN_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/cfn_pkg.sv
// shared types and codes of the closing fee negotiator
// no dependencies
package cfn_pkg;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    OUT_OFFER  = 2'd0,
    OUT_AGREED = 2'd1,
    OUT_FAILED = 2'd2
  } cfn_outcome_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNAFFORD   = 3'd1,
    ERR_BAD_SIG    = 3'd2,
    ERR_MOVED_AWAY = 3'd3,
    ERR_JUMPED     = 3'd4,
    ERR_STALLED    = 3'd5,
    ERR_NOT_ACTIVE = 3'd6
  } cfn_err_t;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_OFFER = 1'b1
  } cfn_op_t;

  typedef enum logic [1:0] {
    REG_MIN_FEE     = 2'd0,
    REG_MAX_FEE     = 2'd1,
    REG_OPENING_FEE = 2'd2,
    REG_FUNDER_BAL  = 2'd3
  } cfn_reg_t;

  typedef struct packed {
    cfn_op_t op;
    logic    sig_ok;
    logic    open_unaff;
    logic    peer_unaff;
    logic    in_range;
  } cfn_class_t;

endpackage

>>> src/cfn_cfg.sv
// configuration registers behind the apb-style port
// depends on cfn_pkg
module cfn_cfg #(
  parameter int FEE_BITS = 51
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cfn_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cfn_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cfn_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic [FEE_BITS-1:0]        min_fee,
  output logic [FEE_BITS-1:0]        max_fee,
  output logic [FEE_BITS-1:0]        opening_fee,
  output logic [FEE_BITS-1:0]        funder_balance
);
  import cfn_pkg::*;

  logic [FEE_BITS-1:0] min_r, max_r, open_r, bal_r;
  cfn_reg_t            idx;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfn_reg_t'(cfg_paddr[CFG_AW-1:3]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      max_r  <= '1;
      open_r <= '0;
      bal_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_FEE:     min_r  <= cfg_pwdata[FEE_BITS-1:0];
        REG_MAX_FEE:     max_r  <= cfg_pwdata[FEE_BITS-1:0];
        REG_OPENING_FEE: open_r <= cfg_pwdata[FEE_BITS-1:0];
        REG_FUNDER_BAL:  bal_r  <= cfg_pwdata[FEE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_MIN_FEE:     cfg_prdata[FEE_BITS-1:0] = min_r;
      REG_MAX_FEE:     cfg_prdata[FEE_BITS-1:0] = max_r;
      REG_OPENING_FEE: cfg_prdata[FEE_BITS-1:0] = open_r;
      REG_FUNDER_BAL:  cfg_prdata[FEE_BITS-1:0] = bal_r;
      default:         cfg_prdata = '0;
    endcase
  end

  assign min_fee        = min_r;
  assign max_fee        = max_r;
  assign opening_fee    = open_r;
  assign funder_balance = bal_r;

endmodule

>>> src/cfn_front.sv
// front end: classifies an incoming transaction against the configuration
// depends on cfn_pkg
module cfn_front #(
  parameter int FEE_BITS = 51
) (
  input  cfn_pkg::cfn_op_t    op,
  input  logic [FEE_BITS-1:0] peer_fee,
  input  logic                signature_ok,
  input  logic [FEE_BITS-1:0] min_fee,
  input  logic [FEE_BITS-1:0] max_fee,
  input  logic [FEE_BITS-1:0] opening_fee,
  input  logic [FEE_BITS-1:0] funder_balance,
  output cfn_pkg::cfn_class_t cls,
  output logic [FEE_BITS-1:0] limit
);
  import cfn_pkg::*;

  logic below_min, above_max;

  assign below_min = peer_fee < min_fee;
  assign above_max = peer_fee > max_fee;

  // clamp into [min, max]; below-min wins when the window is inverted
  always_comb begin
    if (below_min) begin
      limit = min_fee;
    end else if (above_max) begin
      limit = max_fee;
    end else begin
      limit = peer_fee;
    end
    cls.op         = op;
    cls.sig_ok     = signature_ok;
    cls.open_unaff = opening_fee > funder_balance;
    cls.peer_unaff = peer_fee > funder_balance;
    cls.in_range   = !below_min && !above_max;
  end

endmodule

>>> src/cfn_queue.sv
// two-entry queue between front and back end
// depends on nothing
module cfn_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head
);
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign not_full  = cnt_r != 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/cfn_back.sv
// back end: negotiation state, bisection step and result register
// depends on cfn_pkg and the assertion macros
`include "closing_fee_negotiator_defines.svh"
module cfn_back #(
  parameter int FEE_BITS = 51
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  cfn_pkg::cfn_class_t     cls,
  input  logic [FEE_BITS-1:0]     peer,
  input  logic [FEE_BITS-1:0]     limit,
  input  logic [FEE_BITS-1:0]     opening_fee,
  input  logic [FEE_BITS-1:0]     funder_balance,
  output logic                    res_valid,
  input  logic                    res_ready,
  output cfn_pkg::cfn_outcome_t   res_outcome,
  output cfn_pkg::cfn_err_t       res_kind,
  output logic [FEE_BITS-1:0]     res_fee,
  output logic                    res_in_range
);
  import cfn_pkg::*;

  logic [FEE_BITS-1:0] our_r, our_nxt;
  logic [FEE_BITS-1:0] last_r, last_nxt;
  logic                have_r, have_nxt;
  logic                active_r, active_nxt;

  logic                valid_r;
  cfn_outcome_t        outcome_r, outcome_nxt;
  cfn_err_t            kind_r, kind_nxt;
  logic [FEE_BITS-1:0] fee_r, fee_nxt;
  logic                inr_r, inr_nxt;

  logic [FEE_BITS:0]   sum;
  logic [FEE_BITS-1:0] next_fee;
  logic                prev_dir, dir, cross_dir;

  assign q_pop = q_valid && (!valid_r || res_ready);

  // (limit + our - 1) / 2 rounded down; half the limit when our is zero
  assign sum       = {1'b0, limit} + {1'b0, our_r} - {{FEE_BITS{1'b0}}, 1'b1};
  assign next_fee  = (our_r == '0) ? (limit >> 1) : sum[FEE_BITS:1];
  assign prev_dir  = our_r < last_r;
  assign dir       = peer < last_r;
  assign cross_dir = our_r < peer;

  always_comb begin
    our_nxt     = our_r;
    last_nxt    = last_r;
    have_nxt    = have_r;
    active_nxt  = active_r;
    outcome_nxt = OUT_OFFER;
    kind_nxt    = ERR_NONE;
    fee_nxt     = '0;
    inr_nxt     = 1'b0;
    if (cls.op == OP_BEGIN) begin
      our_nxt    = opening_fee;
      last_nxt   = '0;
      have_nxt   = 1'b0;
      active_nxt = !cls.open_unaff;
      if (cls.open_unaff) begin
        outcome_nxt = OUT_FAILED;
        kind_nxt    = ERR_UNAFFORD;
      end else begin
        fee_nxt = opening_fee;
      end
    end else if (!active_r) begin
      outcome_nxt = OUT_FAILED;
      kind_nxt    = ERR_NOT_ACTIVE;
    end else if (cls.peer_unaff) begin
      outcome_nxt = OUT_FAILED;
      kind_nxt    = ERR_UNAFFORD;
      active_nxt  = 1'b0;
    end else if (!cls.sig_ok) begin
      outcome_nxt = OUT_FAILED;
      kind_nxt    = ERR_BAD_SIG;
      active_nxt  = 1'b0;
    end else begin
      inr_nxt = cls.in_range;
      if (peer == our_r) begin
        outcome_nxt = OUT_AGREED;
        fee_nxt     = peer;
        active_nxt  = 1'b0;
      end else if (have_r && (dir != prev_dir)) begin
        outcome_nxt = OUT_FAILED;
        kind_nxt    = ERR_MOVED_AWAY;
        active_nxt  = 1'b0;
      end else if (have_r && (cross_dir != prev_dir)) begin
        outcome_nxt = OUT_FAILED;
        kind_nxt    = ERR_JUMPED;
        active_nxt  = 1'b0;
      end else if (next_fee == our_r) begin
        outcome_nxt = OUT_FAILED;
        kind_nxt    = ERR_STALLED;
        active_nxt  = 1'b0;
      end else begin
        our_nxt  = next_fee;
        last_nxt = peer;
        have_nxt = 1'b1;
        if (next_fee > funder_balance) begin
          outcome_nxt = OUT_FAILED;
          kind_nxt    = ERR_UNAFFORD;
          active_nxt  = 1'b0;
        end else if (next_fee == peer) begin
          outcome_nxt = OUT_AGREED;
          fee_nxt     = next_fee;
          active_nxt  = 1'b0;
        end else begin
          fee_nxt = next_fee;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      our_r    <= '0;
      last_r   <= '0;
      have_r   <= 1'b0;
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        our_r    <= our_nxt;
        last_r   <= last_nxt;
        have_r   <= have_nxt;
        active_r <= active_nxt;
        valid_r  <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      outcome_r <= outcome_nxt;
      kind_r    <= kind_nxt;
      fee_r     <= fee_nxt;
      inr_r     <= inr_nxt;
    end
  end

  assign res_valid    = valid_r;
  assign res_outcome  = outcome_r;
  assign res_kind     = kind_r;
  assign res_fee      = fee_r;
  assign res_in_range = inr_r;

  `CFN_ASSERT(a_fail_zero_fee, clk, rst_n, (valid_r && outcome_r == OUT_FAILED) |-> (fee_r == '0))
  `CFN_ASSERT(a_kind_matches, clk, rst_n, valid_r |-> ((outcome_r == OUT_FAILED) == (kind_r != ERR_NONE)))
  `CFN_ASSERT(a_end_clears_active, clk, rst_n, (q_pop && outcome_nxt != OUT_OFFER) |=> !active_r)
  `CFN_ASSERT(a_offer_keeps_active, clk, rst_n, (q_pop && outcome_nxt == OUT_OFFER) |=> active_r)

endmodule

>>> src/closing_fee_negotiator.sv
// closing fee negotiator top level: negotiates a fee by rounded bisection
// in_* carries begin and peer offer transactions, out_* one result per input
// transaction; cfg_* is an apb-style port with min_fee at 0x00, max_fee at
// 0x08, opening_fee at 0x10 and funder_balance at 0x18 (64-bit data).
// a begin (in_tuser[0] = 0) restarts and answers with the opening offer, or
// with failure when it exceeds funder_balance; a peer offer (in_tuser[0] = 1)
// answers with a counter offer, agreement or failure. the front end classifies
// each transaction against the configuration and pushes it into a two-entry
// queue; the back end takes one entry per cycle while the result register is
// free or being read, runs one compare-and-average step and registers the
// result in the register that drives out_tvalid; throughput is one transaction
// per cycle while out_tready stays high. when out_tready is low the result
// register holds, the queue fills and in_tready falls after two more
// transactions. reset (rst_n low, synchronous) empties the queue and result
// register, stops any negotiation and loads the register defaults (max_fee all
// ones, the rest zero).
// depends on cfn_pkg, cfn_cfg, cfn_front, cfn_queue and cfn_back
module closing_fee_negotiator #(
  parameter int FEE_BITS = 51
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // peer_fee
  input  logic [((FEE_BITS+7)/8)*8-1:0] in_tdata,
  // opcode, signature_ok
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // offer_fee, peer_in_range
  output logic [((FEE_BITS+8)/8)*8-1:0] out_tdata,
  // outcome, error_kind
  output logic [4:0]                    out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cfn_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [cfn_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [cfn_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import cfn_pkg::*;

  localparam int CW = $bits(cfn_class_t);
  localparam int QW = CW + 2 * FEE_BITS;

  logic [FEE_BITS-1:0] min_fee, max_fee, opening_fee, funder_balance;
  cfn_class_t          in_cls, q_cls;
  logic [FEE_BITS-1:0] in_limit, q_limit, q_peer;
  logic [QW-1:0]       q_head;
  logic                q_not_full, q_not_empty, q_pop;
  cfn_outcome_t        res_outcome;
  cfn_err_t            res_kind;
  logic [FEE_BITS-1:0] res_fee;
  logic                res_in_range;

  cfn_cfg #(.FEE_BITS(FEE_BITS)) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .min_fee        (min_fee),
    .max_fee        (max_fee),
    .opening_fee    (opening_fee),
    .funder_balance (funder_balance)
  );

  cfn_front #(.FEE_BITS(FEE_BITS)) u_front (
    .op             (cfn_op_t'(in_tuser[0])),
    .peer_fee       (in_tdata[FEE_BITS-1:0]),
    .signature_ok   (in_tuser[1]),
    .min_fee        (min_fee),
    .max_fee        (max_fee),
    .opening_fee    (opening_fee),
    .funder_balance (funder_balance),
    .cls            (in_cls),
    .limit          (in_limit)
  );

  assign in_tready = q_not_full;

  cfn_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_data ({in_cls, in_tdata[FEE_BITS-1:0], in_limit}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  assign q_cls   = cfn_class_t'(q_head[QW-1:2*FEE_BITS]);
  assign q_peer  = q_head[2*FEE_BITS-1:FEE_BITS];
  assign q_limit = q_head[FEE_BITS-1:0];

  cfn_back #(.FEE_BITS(FEE_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_pop          (q_pop),
    .cls            (q_cls),
    .peer           (q_peer),
    .limit          (q_limit),
    .opening_fee    (opening_fee),
    .funder_balance (funder_balance),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_outcome    (res_outcome),
    .res_kind       (res_kind),
    .res_fee        (res_fee),
    .res_in_range   (res_in_range)
  );

  always_comb begin
    out_tdata                 = '0;
    out_tdata[FEE_BITS-1:0]   = res_fee;
    out_tdata[FEE_BITS]       = res_in_range;
    out_tuser                 = {res_kind, res_outcome};
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench for closing_fee_negotiator: directed and random fee negotiations
// with a built-in predictor, random stalls on both streams and apb setup
// depends on cfn_pkg and the closing_fee_negotiator rtl
`timescale 1ns / 100ps

module tb_top;
  import cfn_pkg::*;

  localparam int FEE_W = 51;
  localparam int IN_DW = ((FEE_W + 7) / 8) * 8;
  localparam int OUT_DW = ((FEE_W + 8) / 8) * 8;

  typedef logic [FEE_W-1:0] fee_t;
  localparam fee_t FEE_MAX = '1;

  typedef struct packed {
    cfn_outcome_t outcome;
    cfn_err_t     err;
    fee_t         fee;
    logic         in_range;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  // peer_fee
  logic [IN_DW-1:0]  in_tdata;
  // opcode, signature_ok
  logic [1:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  // offer_fee, peer_in_range
  logic [OUT_DW-1:0] out_tdata;
  // outcome, error_kind
  logic [4:0]        out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // predictor copy of the fee limits and the negotiation state
  fee_t floor_fee = '0;
  fee_t ceiling_fee = FEE_MAX;
  fee_t start_fee = '0;
  fee_t funder_funds = '0;
  fee_t offered_fee = '0;
  fee_t peer_prev_fee = '0;
  logic peer_prev_valid = 1'b0;
  logic negotiating = 1'b0;

  verdict_t awaited_verdicts[$];
  verdict_t seen;
  bit       idling = 1'b1;
  int       mismatches = 0;
  int       n_sent = 0;
  int       n_offers = 0;
  int       n_agreed = 0;
  int       n_failed = 0;
  int       n_readbacks = 0;
  bit [7:0] kinds_seen = '0;

  closing_fee_negotiator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic void flag_mismatch(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic fee_t rand_fee();
    return fee_t'({$urandom, $urandom});
  endfunction

  // random fee of random magnitude
  function automatic fee_t rand_scaled_fee();
    return rand_fee() >> $urandom_range(0, FEE_W - 1);
  endfunction

  function automatic fee_t fee_between(fee_t lo, fee_t hi);
    logic [63:0] span;
    span = 64'(hi) - 64'(lo) + 64'd1;
    return lo + fee_t'({$urandom, $urandom} % span);
  endfunction

  // one negotiation step: updates the state and returns the expected result
  function automatic verdict_t negotiate_step(cfn_op_t op, fee_t peer, logic sig_ok);
    verdict_t v;
    fee_t     target, next_fee, ours_m1;
    logic     in_rng;
    v = '{OUT_FAILED, ERR_NONE, '0, 1'b0};
    if (op == OP_BEGIN) begin
      offered_fee = start_fee;
      peer_prev_fee = '0;
      peer_prev_valid = 1'b0;
      negotiating = 1'b1;
      if (offered_fee > funder_funds) begin
        v.err = ERR_UNAFFORD;
      end else begin
        v.outcome = OUT_OFFER;
        v.fee = offered_fee;
      end
    end else if (!negotiating) begin
      v.err = ERR_NOT_ACTIVE;
    end else if (peer > funder_funds) begin
      v.err = ERR_UNAFFORD;
    end else if (!sig_ok) begin
      v.err = ERR_BAD_SIG;
    end else begin
      in_rng = 1'b0;
      if (peer < floor_fee) begin
        target = floor_fee;
      end else if (peer > ceiling_fee) begin
        target = ceiling_fee;
      end else begin
        target = peer;
        in_rng = 1'b1;
      end
      v.in_range = in_rng;
      if (peer == offered_fee) begin
        v.outcome = OUT_AGREED;
        v.fee = peer;
      end else if (peer_prev_valid &&
                   ((peer < peer_prev_fee) != (offered_fee < peer_prev_fee))) begin
        v.err = ERR_MOVED_AWAY;
      end else if (peer_prev_valid &&
                   ((offered_fee < peer) != (offered_fee < peer_prev_fee))) begin
        v.err = ERR_JUMPED;
      end else begin
        // average of the clamped offer and ours minus one, rounded down
        if (offered_fee == '0) begin
          next_fee = target >> 1;
        end else begin
          ours_m1 = offered_fee - 1'b1;
          next_fee = (target >> 1) + (ours_m1 >> 1) + fee_t'(target[0] & ours_m1[0]);
        end
        if (next_fee == offered_fee) begin
          v.err = ERR_STALLED;
        end else begin
          peer_prev_fee = peer;
          peer_prev_valid = 1'b1;
          offered_fee = next_fee;
          if (offered_fee > funder_funds) begin
            v.err = ERR_UNAFFORD;
          end else if (offered_fee == peer_prev_fee) begin
            v.outcome = OUT_AGREED;
            v.fee = offered_fee;
          end else begin
            v.outcome = OUT_OFFER;
            v.fee = offered_fee;
          end
        end
      end
    end
    if (v.outcome != OUT_OFFER) negotiating = 1'b0;
    return v;
  endfunction

  // sends one transaction; tvalid stays high so the next one can follow directly
  task automatic push_message(cfn_op_t op, fee_t peer, logic sig_ok);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DW'(peer);
    in_tuser <= {sig_ok, op};
    awaited_verdicts.push_back(negotiate_step(op, peer, sig_ok));
    n_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, cfn_reg_t idx, logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= CFG_AW'({idx, 3'b000});
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_registers();
    logic [CFG_DW-1:0] rd;
    fee_t              vals[4];
    vals = '{floor_fee, ceiling_fee, start_fee, funder_funds};
    for (int i = 0; i < 4; i++) begin
      apb_access(1'b0, cfn_reg_t'(i), '0, rd);
      n_readbacks++;
      if (rd != CFG_DW'(vals[i]))
        flag_mismatch($sformatf("register %0d read %h expected %h",
                                i, rd, vals[i]));
    end
  endtask

  task automatic set_fees(fee_t lo, fee_t hi, fee_t opening, fee_t funds);
    logic [CFG_DW-1:0] rd;
    drain();
    apb_access(1'b1, REG_MIN_FEE, CFG_DW'(lo), rd);
    apb_access(1'b1, REG_MAX_FEE, CFG_DW'(hi), rd);
    apb_access(1'b1, REG_OPENING_FEE, CFG_DW'(opening), rd);
    apb_access(1'b1, REG_FUNDER_BAL, CFG_DW'(funds), rd);
    floor_fee = lo;
    ceiling_fee = hi;
    start_fee = opening;
    funder_funds = funds;
    verify_registers();
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.outcome = cfn_outcome_t'(out_tuser[1:0]);
      seen.err = cfn_err_t'(out_tuser[4:2]);
      seen.fee = out_tdata[FEE_W-1:0];
      seen.in_range = out_tdata[FEE_W];
      if (awaited_verdicts.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", seen));
      end else begin
        if (seen.outcome != awaited_verdicts[0].outcome ||
            seen.err != awaited_verdicts[0].err ||
            seen.fee != awaited_verdicts[0].fee ||
            seen.in_range != awaited_verdicts[0].in_range)
          flag_mismatch($sformatf("expected %p got %p", awaited_verdicts[0], seen));
        case (awaited_verdicts[0].outcome)
          OUT_OFFER:  n_offers++;
          OUT_AGREED: n_agreed++;
          default:    n_failed++;
        endcase
        kinds_seen[awaited_verdicts[0].err] = 1'b1;
        void'(awaited_verdicts.pop_front());
      end
    end
  end

  // receiver pacing
  initial begin
    int n;
    out_tready <= 1'b1;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic test_reset_defaults();
    verify_registers();
    push_message(OP_OFFER, '0, 1'b1);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, '0, 1'b1);
    push_message(OP_BEGIN, FEE_MAX, 1'b0);
    push_message(OP_OFFER, FEE_MAX, 1'b1);
  endtask

  task automatic test_rejections();
    set_fees(51'd1000, 51'd100000, 51'd50000, FEE_MAX);
    push_message(OP_BEGIN, '0, 1'b0);
    push_message(OP_OFFER, FEE_MAX, 1'b0);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd200000, 1'b1);
    push_message(OP_OFFER, 51'd300000, 1'b1);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd90000, 1'b1);
    push_message(OP_OFFER, 51'd60000, 1'b1);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd500, 1'b1);
    push_message(OP_OFFER, 51'd25499, 1'b1);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd50001, 1'b1);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd49999, 1'b1);
  endtask

  task automatic test_clamp_and_funds();
    // min above max, opening at zero, small funder balance
    set_fees(51'd5000, 51'd3000, '0, 51'd4000);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd3500, 1'b1);
    push_message(OP_OFFER, 51'd3000, 1'b1);
    set_fees(51'd5000, 51'd3000, FEE_MAX, 51'd4000);
    push_message(OP_BEGIN, '0, 1'b1);
    push_message(OP_OFFER, 51'd2000, 1'b1);
  endtask

  task automatic run_negotiations(int n_items);
    int   sent, steps, r;
    fee_t peer, lo, hi;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 5) begin
        push_message(OP_OFFER, rand_scaled_fee(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        push_message(OP_BEGIN, rand_fee(), 1'($urandom_range(0, 1)));
        sent++;
        r = $urandom_range(0, 99);
        if (r < 50) peer = fee_between('0, funder_funds);
        else if (r < 75) peer = rand_scaled_fee();
        else peer = fee_between(floor_fee < ceiling_fee ? floor_fee : ceiling_fee,
                                floor_fee < ceiling_fee ? ceiling_fee : floor_fee);
        steps = 0;
        while (negotiating && steps < 60 && sent < n_items) begin
          push_message(OP_OFFER, peer, 1'($urandom_range(0, 99) < 96));
          sent++;
          steps++;
          r = $urandom_range(0, 99);
          if (r < 8) begin
            peer = rand_scaled_fee();
          end else if (r < 14) begin
            peer = offered_fee;
          end else begin
            lo = peer < offered_fee ? peer : offered_fee;
            hi = peer < offered_fee ? offered_fee : peer;
            peer = fee_between(lo, hi);
          end
        end
      end
    end
  endtask

  task automatic test_random_negotiations();
    fee_t a, b;
    idling = 1'b0;
    set_fees('0, FEE_MAX, rand_scaled_fee(), FEE_MAX);
    run_negotiations(100);
    idling = 1'b1;
    a = fee_t'($urandom_range(0, 1 << 22));
    b = a + fee_t'($urandom_range(1, 1 << 22));
    set_fees(a, b, fee_between(a, b), b + fee_t'($urandom_range(0, 1 << 20)));
    run_negotiations(100);
    a = rand_scaled_fee();
    set_fees(a << 1 | 1'b1, a, rand_scaled_fee(), FEE_MAX >> $urandom_range(0, 8));
    run_negotiations(100);
    a = rand_scaled_fee();
    set_fees(a, a, fee_between('0, a), FEE_MAX);
    run_negotiations(100);
    set_fees(rand_fee(), rand_fee(), rand_fee(), rand_fee());
    run_negotiations(100);
    set_fees(fee_t'($urandom_range(0, 16)), fee_t'($urandom_range(16, 63)),
             fee_t'($urandom_range(0, 63)), fee_t'($urandom_range(32, 80)));
    run_negotiations(100);
    set_fees(FEE_MAX, '0, '0, FEE_MAX);
    run_negotiations(30);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_rejections();
    test_clamp_and_funds();
    test_random_negotiations();
    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d transactions: %0d counter offers, %0d agreements, %0d failures",
             n_sent, n_offers, n_agreed, n_failed);
    $display("error codes seen (bit per code) %b, %0d register readbacks, %0d mismatches",
             kinds_seen, n_readbacks, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", awaited_verdicts.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> closing_fee_negotiator.f
+incdir+src
src/cfn_pkg.sv
src/cfn_cfg.sv
src/cfn_front.sv
src/cfn_queue.sv
src/cfn_back.sv
src/closing_fee_negotiator.sv
tb/sv/tb_top.sv
